[design/rcmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rcmc_pkg;

  localparam int unsigned MAX_VERTICES = 256;
  localparam int unsigned MAX_EDGES    = 8192;
  localparam int unsigned VW   = $clog2(MAX_VERTICES);  // vertex id width
  localparam int unsigned EW   = $clog2(MAX_EDGES);     // edge slot width
  localparam int unsigned ECW  = EW + 1;                // edge count width
  localparam int unsigned VCW  = VW + 1;                // vertex count width
  localparam int unsigned RKW  = 4;                     // rank width
  localparam int unsigned DRW  = 21;                    // draw counter width
  localparam int unsigned SEEDW = 32;

  localparam logic [DRW-1:0]   DRAW_LIMIT = DRW'(1) << 20;
  localparam logic [SEEDW-1:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [ECW-1:0]   BEST_RESET = ECW'(MAX_EDGES);
  localparam logic [RKW-1:0]   RANK_MAX   = '1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_EDGE_COUNT   = 1'b1;
  localparam int unsigned CFGW = 14;

  typedef struct packed {
    logic             command;
    logic [EW-1:0]    edge_index;
    logic [VW-1:0]    src_vertex;
    logic [VW-1:0]    dst_vertex;
    logic [SEEDW-1:0] trial_seed;
  } in_word_t;

  typedef struct packed {
    logic [ECW-1:0] cut_size;
    logic [ECW-1:0] best_cut;
    logic           stuck;
  } out_word_t;

endpackage
`default_nettype wire

[design/rcmc_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
// serial remainder, one dividend bit per cycle
module rcmc_mod (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rcmc_pkg::SEEDW-1:0]    dividend_i,
  input  wire logic [rcmc_pkg::ECW-1:0]      divisor_i,
  output      logic                          done_o,
  output      logic [rcmc_pkg::EW-1:0]       rem_o
);

  logic                       busy_q, busy_d, done_q, done_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic [rcmc_pkg::SEEDW-1:0] num_q, num_d;
  logic [rcmc_pkg::EW-1:0]    rem_q, rem_d;
  logic [rcmc_pkg::ECW-1:0]   dvs_q, dvs_d;
  logic [rcmc_pkg::ECW-1:0]   shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, num_q[rcmc_pkg::SEEDW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[rcmc_pkg::SEEDW-2:0], 1'b0};
      if (shifted >= dvs_q) begin
        rem_d = rcmc_pkg::EW'(shifted - dvs_q);
      end else begin
        rem_d = rcmc_pkg::EW'(shifted);
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

[design/random_contraction_min_cut.sv]
`timescale 1ns / 1ps
`default_nettype none
// random contraction min cut, union-find with union by rank
// load word: written to the edge store, a new word may follow in the next cycle
// run word: clear every set, then per draw a check, a remainder, an edge read and both chain walks,
//   two rank reads and a merge on a merge; per edge a read and both chain walks, a final check, emit
// one word at a time; the serial remainder unit paces every draw
// async active-low reset clears control, config to 256 / 8192, best cut to 8192
module random_contraction_min_cut (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire rcmc_pkg::in_word_t           in_data_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      rcmc_pkg::out_word_t          out_data_o,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic                         cfg_index_i,
  input  wire logic [rcmc_pkg::CFGW-1:0]    cfg_data_i
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLEAR = 11'b000_0000_0010,
    S_CHECK = 11'b000_0000_0100,
    S_DIV   = 11'b000_0000_1000,
    S_EREQ  = 11'b000_0001_0000,
    S_EDAT  = 11'b000_0010_0000,
    S_FIND  = 11'b000_0100_0000,
    S_RKA   = 11'b000_1000_0000,
    S_RKB   = 11'b001_0000_0000,
    S_MERGE = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  localparam int unsigned VW  = rcmc_pkg::VW;
  localparam int unsigned EW  = rcmc_pkg::EW;
  localparam int unsigned ECW = rcmc_pkg::ECW;
  localparam int unsigned VCW = rcmc_pkg::VCW;
  localparam int unsigned RKW = rcmc_pkg::RKW;

  state_e state_q, state_d;

  // configuration registers
  logic [VCW-1:0] vc_q;
  logic [ECW-1:0] ec_q;
  logic [VCW-1:0] vc_eff;
  logic [ECW-1:0] ec_eff;

  // trial state
  logic [31:0]            lfsr_q, lfsr_d, lfsr_next;
  logic [VCW-1:0]         remain_q, remain_d;
  logic [rcmc_pkg::DRW-1:0] draws_q, draws_d;
  logic [VW-1:0]          clr_q, clr_d;
  logic                   counting_q, counting_d;
  logic                   stuck_q, stuck_d;
  logic [ECW-1:0]         cut_q, cut_d;
  logic [ECW-1:0]         best_q, best_d;
  logic [ECW-1:0]         ei_q, ei_d;       // edge walk index while counting
  logic [EW-1:0]          draw_idx_q, draw_idx_d;
  logic [VW-1:0]          dst_q, dst_d;
  logic [VW-1:0]          cur_q, cur_d;
  logic [VCW-1:0]         steps_q, steps_d;
  logic                   which_q, which_d; // 0 walking source, 1 walking target
  logic [VW-1:0]          ra_q, ra_d, rb_q, rb_d;
  logic [RKW-1:0]         rka_q, rka_d;
  logic                   found;

  // output register
  logic                   out_valid_q, out_valid_d;
  rcmc_pkg::out_word_t    out_q, out_d;

  // edge store
  logic [2*VW-1:0] edge_mem [rcmc_pkg::MAX_EDGES];
  logic            e_we;
  logic [EW-1:0]   e_raddr;
  logic [2*VW-1:0] e_rd_q;

  // parent and rank stores
  logic [VW-1:0]   par_mem  [rcmc_pkg::MAX_VERTICES];
  logic [RKW-1:0]  rank_mem [rcmc_pkg::MAX_VERTICES];
  logic            p_we, r_we;
  logic [VW-1:0]   p_waddr, p_wdata, r_waddr, p_raddr, r_raddr;
  logic [RKW-1:0]  r_wdata;
  logic [VW-1:0]   p_rd_q;
  logic [RKW-1:0]  r_rd_q;

  // serial remainder unit
  logic            div_start, div_done;
  logic [EW-1:0]   div_rem;

  logic in_accept;

  rcmc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lfsr_next),
    .divisor_i  (ec_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // clamp the configured counts
  assign vc_eff = (vc_q > VCW'(rcmc_pkg::MAX_VERTICES)) ? VCW'(rcmc_pkg::MAX_VERTICES) : vc_q;
  always_comb begin
    if (ec_q == '0) begin
      ec_eff = ECW'(1);
    end else if (ec_q > ECW'(rcmc_pkg::MAX_EDGES)) begin
      ec_eff = ECW'(rcmc_pkg::MAX_EDGES);
    end else begin
      ec_eff = ec_q;
    end
  end

  // galois step
  assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? rcmc_pkg::LFSR_TAPS : 32'd0);

  assign found = (p_rd_q == cur_q) || (steps_q == VCW'(rcmc_pkg::MAX_VERTICES));

  always_comb begin
    state_d     = state_q;
    lfsr_d      = lfsr_q;
    remain_d    = remain_q;
    draws_d     = draws_q;
    clr_d       = clr_q;
    counting_d  = counting_q;
    stuck_d     = stuck_q;
    cut_d       = cut_q;
    best_d      = best_q;
    ei_d        = ei_q;
    draw_idx_d  = draw_idx_q;
    dst_d       = dst_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    which_d     = which_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    rka_d       = rka_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    e_we        = 1'b0;
    e_raddr     = counting_q ? ei_q[EW-1:0] : draw_idx_q;
    p_we        = 1'b0;
    p_waddr     = clr_q;
    p_wdata     = clr_q;
    p_raddr     = cur_q;
    r_we        = 1'b0;
    r_waddr     = clr_q;
    r_wdata     = '0;
    r_raddr     = ra_q;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data_i.command == rcmc_pkg::CMD_LOAD) begin
            e_we = 1'b1;
          end else begin
            lfsr_d     = in_data_i.trial_seed;
            remain_d   = vc_eff;
            draws_d    = '0;
            clr_d      = '0;
            counting_d = 1'b0;
            stuck_d    = 1'b0;
            cut_d      = '0;
            ei_d       = '0;
            state_d    = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        // every vertex back to a singleton of rank zero
        p_we    = 1'b1;
        r_we    = 1'b1;
        clr_d   = clr_q + VW'(1);
        if (clr_q == '1) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (remain_q > VCW'(2)) begin
          if (draws_q == rcmc_pkg::DRAW_LIMIT) begin
            stuck_d    = 1'b1;
            counting_d = 1'b1;
            state_d    = S_EREQ;
          end else begin
            draws_d   = draws_q + rcmc_pkg::DRW'(1);
            lfsr_d    = lfsr_next;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end else begin
          counting_d = 1'b1;
          state_d    = S_EREQ;
        end
      end
      S_DIV: begin
        if (div_done) begin
          draw_idx_d = div_rem;
          state_d    = S_EREQ;
        end
      end
      S_EREQ: begin
        state_d = S_EDAT;
      end
      S_EDAT: begin
        cur_d   = e_rd_q[2*VW-1:VW];
        dst_d   = e_rd_q[VW-1:0];
        steps_d = '0;
        which_d = 1'b0;
        p_raddr = e_rd_q[2*VW-1:VW];
        state_d = S_FIND;
      end
      S_FIND: begin
        // walk the parent chain one link per cycle
        if (!found) begin
          cur_d   = p_rd_q;
          steps_d = steps_q + VCW'(1);
          p_raddr = p_rd_q;
        end else if (!which_q) begin
          ra_d    = cur_q;
          cur_d   = dst_q;
          steps_d = '0;
          which_d = 1'b1;
          p_raddr = dst_q;
        end else begin
          rb_d = cur_q;
          if (counting_q) begin
            if (ra_q != cur_q) begin
              cut_d = cut_q + ECW'(1);
            end
            ei_d = ei_q + ECW'(1);
            if ((ei_q + ECW'(1)) == ec_eff) begin
              state_d = S_OUT;
            end else begin
              state_d = S_EREQ;
            end
          end else if (ra_q != cur_q) begin
            remain_d = remain_q - VCW'(1);
            state_d  = S_RKA;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_RKA: begin
        r_raddr = ra_q;
        state_d = S_RKB;
      end
      S_RKB: begin
        rka_d   = r_rd_q;
        r_raddr = rb_q;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        // lower rank goes under, ties put the source root under the target root
        p_we = 1'b1;
        if (rka_q < r_rd_q) begin
          p_waddr = ra_q;
          p_wdata = rb_q;
        end else if (r_rd_q < rka_q) begin
          p_waddr = rb_q;
          p_wdata = ra_q;
        end else begin
          p_waddr = ra_q;
          p_wdata = rb_q;
          r_we    = 1'b1;
          r_waddr = rb_q;
          r_wdata = (r_rd_q == rcmc_pkg::RANK_MAX) ? r_rd_q : r_rd_q + RKW'(1);
        end
        state_d = S_CHECK;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          if (cut_q < best_q) begin
            best_d = cut_q;
          end
          out_valid_d    = 1'b1;
          out_d.cut_size = cut_q;
          out_d.best_cut = (cut_q < best_q) ? cut_q : best_q;
          out_d.stuck    = stuck_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vc_q        <= VCW'(rcmc_pkg::MAX_VERTICES);
      ec_q        <= ECW'(rcmc_pkg::MAX_EDGES);
      best_q      <= rcmc_pkg::BEST_RESET;
      out_valid_q <= 1'b0;
      counting_q  <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
      counting_q  <= counting_d;
      clr_q       <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == rcmc_pkg::CFG_VERTEX_COUNT) begin
          vc_q <= cfg_data_i[VCW-1:0];
        end else begin
          vc_q <= vc_q;
        end
        if (cfg_index_i == rcmc_pkg::CFG_EDGE_COUNT) begin
          ec_q <= cfg_data_i[ECW-1:0];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lfsr_q     <= lfsr_d;
    remain_q   <= remain_d;
    draws_q    <= draws_d;
    stuck_q    <= stuck_d;
    cut_q      <= cut_d;
    ei_q       <= ei_d;
    draw_idx_q <= draw_idx_d;
    dst_q      <= dst_d;
    cur_q      <= cur_d;
    steps_q    <= steps_d;
    which_q    <= which_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    rka_q      <= rka_d;
    out_q      <= out_d;
  end

  // memories, registered reads
  always_ff @(posedge clk_i) begin
    if (e_we) begin
      edge_mem[in_data_i.edge_index] <= {in_data_i.src_vertex, in_data_i.dst_vertex};
    end
    e_rd_q <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      par_mem[p_waddr] <= p_wdata;
    end
    p_rd_q <= par_mem[p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rank_mem[r_waddr] <= r_wdata;
    end
    r_rd_q <= rank_mem[r_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[design/rcmc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module rcmc_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire rcmc_pkg::in_word_t        in_data_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire rcmc_pkg::out_word_t       out_data_o
);

  // a held result word keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // a taken run word raises the input stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == rcmc_pkg::CMD_RUN) |=> in_stall_o)
    else $error("input taken during a trial");

  // best cut never exceeds the cut of the same word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.best_cut <= out_data_o.cut_size)
    else $error("best cut above trial cut");

  // a load word produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && !in_stall_o && (in_data_i.command == rcmc_pkg::CMD_LOAD)
    |=> !out_valid_o)
    else $error("result word after a load");

endmodule

bind random_contraction_min_cut rcmc_checker u_rcmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

[sim/tb_random_contraction_min_cut.sv]
`timescale 1ns / 1ps
module tb_random_contraction_min_cut;

  localparam int unsigned MAX_VERTICES = rcmc_pkg::MAX_VERTICES;
  localparam int unsigned MAX_EDGES    = rcmc_pkg::MAX_EDGES;
  localparam int unsigned VW           = rcmc_pkg::VW;
  localparam int unsigned EW           = rcmc_pkg::EW;
  localparam int unsigned ECW          = rcmc_pkg::ECW;
  localparam int unsigned VCW          = rcmc_pkg::VCW;
  localparam int unsigned SEEDW        = rcmc_pkg::SEEDW;
  localparam int unsigned CFGW         = rcmc_pkg::CFGW;
  localparam logic [rcmc_pkg::DRW-1:0] DRAW_LIMIT = rcmc_pkg::DRAW_LIMIT;
  localparam logic [SEEDW-1:0]         LFSR_TAPS  = rcmc_pkg::LFSR_TAPS;
  localparam logic [ECW-1:0]           BEST_RESET = rcmc_pkg::BEST_RESET;
  localparam logic CMD_LOAD         = rcmc_pkg::CMD_LOAD;
  localparam logic CMD_RUN          = rcmc_pkg::CMD_RUN;
  localparam logic CFG_VERTEX_COUNT = rcmc_pkg::CFG_VERTEX_COUNT;
  localparam logic CFG_EDGE_COUNT   = rcmc_pkg::CFG_EDGE_COUNT;

  typedef rcmc_pkg::in_word_t  in_word_t;
  typedef rcmc_pkg::out_word_t out_word_t;

  localparam int unsigned WATCHDOG_LIMIT = 2000000;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned TARGET_ITEMS   = 1350;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  // one row of the directed table; cfg rows carry index in edge_index and data in trial_seed
  typedef struct {
    row_kind_e   kind;
    in_word_t    w;
    bit          typed;
    out_word_t   res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [CFGW-1:0] cfg_data_i = '0;

  random_contraction_min_cut i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block: edge store, sets, best cut, registers
  logic [VW-1:0]  edge_src_mem [MAX_EDGES];
  logic [VW-1:0]  edge_dst_mem [MAX_EDGES];
  int unsigned    parent_of [MAX_VERTICES];
  int unsigned    rank_of [MAX_VERTICES];
  logic [ECW-1:0] best_cut_q;
  logic [VCW-1:0] vertex_count_q;
  logic [ECW-1:0] edge_count_q;

  out_word_t pending_cuts[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned idle_mode = 0;  // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
  bit hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned find_root(int unsigned v);
    int unsigned steps;
    steps = 0;
    v = v % MAX_VERTICES;
    while (parent_of[v] != v && steps < MAX_VERTICES) begin
      v = parent_of[v] % MAX_VERTICES;
      steps++;
    end
    return v;
  endfunction

  // one full contraction trial over the shadow store
  function automatic out_word_t contract_trial(logic [SEEDW-1:0] seed);
    int unsigned vcn, ecn, left, draws, k, a, b, cut;
    logic [SEEDW-1:0] r;
    out_word_t o;
    vcn = vertex_count_q;
    if (vcn > MAX_VERTICES) vcn = MAX_VERTICES;
    ecn = edge_count_q;
    if (ecn == 0) ecn = 1;
    if (ecn > MAX_EDGES) ecn = MAX_EDGES;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      parent_of[i] = i;
      rank_of[i] = 0;
    end
    r = seed;
    left = vcn;
    draws = 0;
    o.stuck = 1'b0;
    while (left > 2) begin
      if (draws >= 32'(DRAW_LIMIT)) begin
        o.stuck = 1'b1;
        break;
      end
      draws++;
      r = (r >> 1) ^ (r[0] ? LFSR_TAPS : '0);
      k = r % ecn;
      a = find_root(edge_src_mem[k]);
      b = find_root(edge_dst_mem[k]);
      if (a != b) begin
        left--;
        if (rank_of[a] < rank_of[b]) begin
          parent_of[a] = b;
        end else if (rank_of[b] < rank_of[a]) begin
          parent_of[b] = a;
        end else begin
          parent_of[a] = b;
          if (rank_of[b] < 15) rank_of[b]++;
        end
      end
    end
    cut = 0;
    for (int unsigned i = 0; i < ecn; i++) begin
      if (find_root(edge_src_mem[i]) != find_root(edge_dst_mem[i])) cut++;
    end
    if (cut < best_cut_q) best_cut_q = ECW'(cut);
    o.cut_size = ECW'(cut);
    o.best_cut = best_cut_q;
    return o;
  endfunction

  // returns the predicted result of an accepted word, valid only for runs
  function automatic out_word_t take_word(in_word_t w);
    out_word_t o;
    o = '0;
    if (w.command == CMD_LOAD) begin
      edge_src_mem[w.edge_index] = w.src_vertex;
      edge_dst_mem[w.edge_index] = w.dst_vertex;
    end else begin
      o = contract_trial(w.trial_seed);
    end
    return o;
  endfunction

  task automatic sender_gap();
    if ((idle_mode == 1 && $urandom_range(99) < 60) ||
        (idle_mode == 3 && $urandom_range(99) < 25)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // offer one word, keep it steady until taken; typed result overrides the prediction
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
    out_word_t o;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    o = take_word(w);
    if (w.command == CMD_RUN) pending_cuts.push_back(typed ? typed_res : o);
    items_sent++;
    sender_gap();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cuts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFGW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_VERTEX_COUNT) vertex_count_q = data[VCW-1:0];
    else edge_count_q = data;
  endtask

  task automatic load_edge(int unsigned idx, int unsigned s, int unsigned d);
    in_word_t w;
    w = '0;
    w.command = CMD_LOAD;
    w.edge_index = EW'(idx);
    w.src_vertex = VW'(s);
    w.dst_vertex = VW'(d);
    w.trial_seed = $urandom();
    send_word(w, 1'b0, '0);
  endtask

  task automatic start_trial(logic [SEEDW-1:0] seed);
    in_word_t w;
    w = '0;
    w.command = CMD_RUN;
    w.edge_index = EW'($urandom());
    w.src_vertex = VW'($urandom());
    w.dst_vertex = VW'($urandom());
    w.trial_seed = seed;
    send_word(w, 1'b0, '0);
  endtask

  // random endpoint, mostly inside the vertices in use, sometimes anywhere
  function automatic int unsigned pick_vertex(int unsigned vce);
    if (vce == 0 || $urandom_range(99) < 20) return $urandom_range(255);
    return $urandom_range(vce - 1);
  endfunction

  // one setting: write both registers, load a spanning chain first so no trial
  // can get stuck, then trials with random seeds and extra loads in between
  task automatic run_phase(int unsigned vcw, int unsigned ecw, int unsigned trials,
                           bit pressure);
    int unsigned vce, ece, chain, idx;
    logic [CFGW-1:0] vdata;
    vdata = {5'($urandom_range(31)), 9'(vcw)};
    write_reg(CFG_VERTEX_COUNT, vdata);
    write_reg(CFG_EDGE_COUNT, CFGW'(ecw));
    vce = (vcw > MAX_VERTICES) ? MAX_VERTICES : vcw;
    ece = (ecw == 0) ? 1 : ((ecw > MAX_EDGES) ? MAX_EDGES : ecw);
    chain = (vce > 2) ? vce - 1 : 0;
    for (int unsigned i = 0; i < ece; i++) begin
      if (i < chain) begin
        if ($urandom_range(1)) load_edge(i, i + 1, $urandom_range(i));
        else load_edge(i, $urandom_range(i), i + 1);
      end else begin
        load_edge(i, pick_vertex(vce), pick_vertex(vce));
      end
    end
    if (pressure) hold_go = 1'b1;
    for (int unsigned t = 0; t < trials; t++) begin
      repeat ($urandom_range(0, 3)) begin
        // never touch the chain, the rest of the store is fair game
        idx = $urandom_range(chain, MAX_EDGES - 1);
        load_edge(idx, pick_vertex(vce), pick_vertex(vce));
      end
      start_trial($urandom());
      if ($urandom_range(99) < 15) drain();
    end
  endtask

  // receiver: check every taken result, then pick the next stall
  initial begin
    out_word_t e;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_cuts.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = pending_cuts.pop_front();
          if (out_data_o.cut_size !== e.cut_size) begin
            $error("cut_size expected %0d actual %0d", e.cut_size, out_data_o.cut_size);
            errors++;
          end
          if (out_data_o.best_cut !== e.best_cut) begin
            $error("best_cut expected %0d actual %0d", e.best_cut, out_data_o.best_cut);
            errors++;
          end
          if (out_data_o.stuck !== e.stuck) begin
            $error("stuck expected %0d actual %0d", e.stuck, out_data_o.stuck);
            errors++;
          end
        end
      end
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (idle_mode == 2) begin
        out_stall_i <= ($urandom_range(99) < 60);
      end else if (idle_mode == 3) begin
        out_stall_i <= ($urandom_range(99) < 25);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles where no handshake completes
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  row_t directed [$];

  function automatic row_t mk_row(row_kind_e kind, logic cmd, int unsigned idx,
                                  int unsigned s, int unsigned d, logic [31:0] seed,
                                  bit typed, int unsigned cut, int unsigned best);
    row_t r;
    r.kind = kind;
    r.w.command = cmd;
    r.w.edge_index = EW'(idx);
    r.w.src_vertex = VW'(s);
    r.w.dst_vertex = VW'(d);
    r.w.trial_seed = seed;
    r.typed = typed;
    r.res.cut_size = ECW'(cut);
    r.res.best_cut = ECW'(best);
    r.res.stuck = 1'b0;
    return r;
  endfunction

  initial begin
    int unsigned vc, ec, ph;
    for (int i = 0; i < MAX_EDGES; i++) begin
      edge_src_mem[i] = '0;
      edge_dst_mem[i] = '0;
    end
    best_cut_q = BEST_RESET;
    vertex_count_q = VCW'(MAX_VERTICES);
    edge_count_q = ECW'(MAX_EDGES);

    // two vertices, edge count zero acts as one
    directed.push_back(mk_row(ROW_CFG, 0, CFG_VERTEX_COUNT, 0, 0, 2, 0, 0, 0));
    directed.push_back(mk_row(ROW_CFG, 0, CFG_EDGE_COUNT, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_LOAD, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_RUN, 0, 0, 0, 1, 1, 1, 1));
    directed.push_back(mk_row(ROW_WORD, CMD_LOAD, 0, 5, 5, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_RUN, 8191, 255, 255, 32'hffff_ffff, 1, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_LOAD, 8191, 255, 255, 32'hffff_ffff, 0, 0, 0));
    // endpoint beyond the vertex count is its own set
    directed.push_back(mk_row(ROW_WORD, CMD_LOAD, 0, 255, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_RUN, 0, 0, 0, 32'h8000_0000, 1, 1, 0));
    // three vertices, zero seed keeps drawing edge zero
    directed.push_back(mk_row(ROW_CFG, 0, CFG_VERTEX_COUNT, 0, 0, 14'h3e03, 0, 0, 0));
    directed.push_back(mk_row(ROW_CFG, 0, CFG_EDGE_COUNT, 0, 0, 2, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_LOAD, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_LOAD, 1, 1, 2, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_RUN, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_RUN, 0, 0, 0, 7, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_LOAD, 1, 2, 1, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_RUN, 0, 0, 0, 32'h0000_0001, 0, 0, 0));
    // one and zero vertices: no contraction, both edges cross
    directed.push_back(mk_row(ROW_CFG, 0, CFG_VERTEX_COUNT, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_RUN, 0, 0, 0, 3, 1, 2, 0));
    directed.push_back(mk_row(ROW_CFG, 0, CFG_VERTEX_COUNT, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(ROW_WORD, CMD_RUN, 0, 0, 0, 32'h1234_5678, 1, 2, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_reg(directed[i].w.edge_index[0], directed[i].w.trial_seed[CFGW-1:0]);
      end else begin
        send_word(directed[i].w, directed[i].typed, directed[i].res);
      end
    end

    // random settings, small graphs keep trials short
    ph = 0;
    while (items_sent < TARGET_ITEMS) begin
      idle_mode = ph % 4;
      if ($urandom_range(99) < 10) vc = $urandom_range(2);
      else vc = $urandom_range(3, 8);
      ec = $urandom_range((vc > 2) ? vc - 1 : 0, 24);
      run_phase(vc, ec, $urandom_range(3, 6), (ph == 5));
      ph++;
    end

    // widest vertex setting, clamped to the full vertex range
    idle_mode = 3;
    run_phase(511, 300, 1, 1'b0);

    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending_cuts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
